// File: sv/cdad_pkg.sv
// shared types, constants and month-length helpers for the calendar date adder
package cdad_pkg;

    localparam int OFFSET_BITS = 17;
    localparam int DAY_W       = OFFSET_BITS + 1;
    localparam int YEAR_W      = 15;
    localparam int MOD_STEPS   = 6;

    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [13:0] MOD_BASE  = 14'd400;
    localparam logic [8:0]  MOD_LAST  = 9'd399;
    localparam logic [4:0]  DAY_FIRST = 5'd1;
    localparam logic [4:0]  DAY_LAST  = 5'd31;

    localparam logic signed [YEAR_W-1:0] YEAR_LIMIT = 15'sd9999;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_FWD,
        ST_BACK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [DAY_W-1:0]  day;
        logic [3:0]               month;
        logic signed [YEAR_W-1:0] year;
        logic [8:0]               mod400;
    } t_work;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        out_of_range;
    } t_result;

    function automatic logic f_is_leap(input logic [1:0] year_lo, input logic [8:0] mod400);
        logic century;
        century = (mod400 == 9'd100) || (mod400 == 9'd200) || (mod400 == 9'd300);
        return (year_lo == 2'd0) && !century;
    endfunction

    function automatic logic [4:0] f_month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

// File: sv/cdad_step.sv
// shared month step unit: one month forward or back with a single day adder
module cdad_step (
    input  cdad_pkg::t_work i_work,
    input  logic            i_back,
    output cdad_pkg::t_work o_work,
    output logic            o_go
);

    logic                               leap;
    logic                               wrap;
    logic [3:0]                         month_t;
    logic [4:0]                         len;
    logic signed [cdad_pkg::DAY_W-1:0]  len_ext;
    logic signed [cdad_pkg::DAY_W-1:0]  sum;
    logic                               day_low;
    cdad_pkg::t_work                    nxt;

    always_comb begin
        leap    = cdad_pkg::f_is_leap(i_work.year[1:0], i_work.mod400);
        nxt     = i_work;
        wrap    = 1'b0;
        month_t = i_work.month;
        if (i_back) begin
            wrap    = (i_work.month == cdad_pkg::MONTH_JAN);
            month_t = wrap ? cdad_pkg::MONTH_DEC : i_work.month - 4'd1;
        end else begin
            wrap = (i_work.month == cdad_pkg::MONTH_DEC);
        end
        len     = cdad_pkg::f_month_len(month_t, leap);
        len_ext = {{(cdad_pkg::DAY_W-5){1'b0}}, len};
        sum     = i_back ? (i_work.day + len_ext) : (i_work.day - len_ext);
        day_low = i_work.day[cdad_pkg::DAY_W-1] || (i_work.day == '0);
        nxt.day = sum;
        if (i_back) begin
            o_go      = day_low && !i_work.year[cdad_pkg::YEAR_W-1];
            nxt.month = month_t;
            if (wrap) begin
                nxt.year   = i_work.year - 15'sd1;
                nxt.mod400 = (i_work.mod400 == 9'd0) ? cdad_pkg::MOD_LAST
                                                     : i_work.mod400 - 9'd1;
            end
        end else begin
            o_go      = (i_work.day > len_ext) && !(i_work.year > cdad_pkg::YEAR_LIMIT);
            nxt.month = wrap ? cdad_pkg::MONTH_JAN : i_work.month + 4'd1;
            if (wrap) begin
                nxt.year   = i_work.year + 15'sd1;
                nxt.mod400 = (i_work.mod400 == cdad_pkg::MOD_LAST) ? 9'd0
                                                                   : i_work.mod400 + 9'd1;
            end
        end
        o_work = o_go ? nxt : i_work;
    end

endmodule

// File: sv/cdad_seq.sv
// sequencer: loads an item, finds year mod 400, walks months, saturates the result
module cdad_seq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [13:0]                         i_start_year,
    input  logic [3:0]                          i_start_month,
    input  logic [4:0]                          i_start_day,
    input  logic signed [cdad_pkg::OFFSET_BITS-1:0] i_day_offset,
    input  logic                                i_out_free,
    output logic                                o_busy,
    output logic                                o_done,
    output cdad_pkg::t_result                   o_result
);

    cdad_pkg::t_state r_state, n_state;
    cdad_pkg::t_work  r_work, n_work;
    logic [2:0]       r_cnt, n_cnt;
    logic [13:0]      r_rem, n_rem;

    cdad_pkg::t_work  step_work;
    logic             step_go;
    logic [13:0]      sub_val;
    logic [3:0]       month_in;
    logic [cdad_pkg::DAY_W-1:0] day_start;

    cdad_step u_step (
        .i_work (r_work),
        .i_back (r_state == cdad_pkg::ST_BACK),
        .o_work (step_work),
        .o_go   (step_go)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdad_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
    end

    always_comb begin
        n_state   = r_state;
        n_work    = r_work;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        sub_val   = cdad_pkg::MOD_BASE << (3'(cdad_pkg::MOD_STEPS - 1) - r_cnt);
        day_start = {{(cdad_pkg::DAY_W-5){1'b0}}, i_start_day};
        if (i_start_month == 4'd0) begin
            month_in = cdad_pkg::MONTH_JAN;
        end else if (i_start_month > cdad_pkg::MONTH_DEC) begin
            month_in = cdad_pkg::MONTH_DEC;
        end else begin
            month_in = i_start_month;
        end
        case (r_state)
            cdad_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_work.day    = day_start + cdad_pkg::DAY_W'(i_day_offset);
                    n_work.month  = month_in;
                    n_work.year   = {1'b0, i_start_year};
                    n_work.mod400 = 9'd0;
                    n_rem         = i_start_year;
                    n_cnt         = 3'd0;
                    n_state       = cdad_pkg::ST_MOD;
                end
            end
            cdad_pkg::ST_MOD: begin
                if (r_rem >= sub_val) begin
                    n_rem = r_rem - sub_val;
                end
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'(cdad_pkg::MOD_STEPS - 1)) begin
                    n_work.mod400 = n_rem[8:0];
                    n_state       = cdad_pkg::ST_FWD;
                end
            end
            cdad_pkg::ST_FWD: begin
                if (step_go) begin
                    n_work = step_work;
                end else begin
                    n_state = cdad_pkg::ST_BACK;
                end
            end
            cdad_pkg::ST_BACK: begin
                if (step_go) begin
                    n_work = step_work;
                end else begin
                    n_state = cdad_pkg::ST_DONE;
                end
            end
            cdad_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = cdad_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cdad_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (r_work.year > cdad_pkg::YEAR_LIMIT) begin
            o_result.year         = cdad_pkg::YEAR_MAX;
            o_result.month        = cdad_pkg::MONTH_DEC;
            o_result.day          = cdad_pkg::DAY_LAST;
            o_result.out_of_range = 1'b1;
        end else if (r_work.year[cdad_pkg::YEAR_W-1]) begin
            o_result.year         = 14'd0;
            o_result.month        = cdad_pkg::MONTH_JAN;
            o_result.day          = cdad_pkg::DAY_FIRST;
            o_result.out_of_range = 1'b1;
        end else begin
            o_result.year         = r_work.year[13:0];
            o_result.month        = r_work.month;
            o_result.day          = r_work.day[4:0];
            o_result.out_of_range = 1'b0;
        end
    end

    assign o_busy = (r_state != cdad_pkg::ST_IDLE);
    assign o_done = (r_state == cdad_pkg::ST_DONE) && i_out_free;

endmodule

// File: sv/calendar_date_add_days.sv
// an item passes through the mod 400 search, the forward walk and the back walk
// the month walk runs one month per cycle through the shared step unit
// year mod 400 is found first by 6 restoring subtract steps
// a new item is taken only once the last one has left the sequencer
// a result waits in the sequencer while a stalled one holds the output register
// reset (synchronous, active low) clears the sequencer and the output valid
module calendar_date_add_days (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [13:0]                             i_start_year,
    input  logic [3:0]                              i_start_month,
    input  logic [4:0]                              i_start_day,
    input  logic signed [cdad_pkg::OFFSET_BITS-1:0] i_day_offset,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [13:0]                             o_result_year,
    output logic [3:0]                              o_result_month,
    output logic [4:0]                              o_result_day,
    output logic                                    o_year_out_of_range
);

    logic              busy;
    logic              done;
    logic              out_free;
    cdad_pkg::t_result result;
    cdad_pkg::t_result r_out;
    logic              r_out_valid;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = busy;

    cdad_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_valid && !busy),
        .i_start_year  (i_start_year),
        .i_start_month (i_start_month),
        .i_start_day   (i_start_day),
        .i_day_offset  (i_day_offset),
        .i_out_free    (out_free),
        .o_busy        (busy),
        .o_done        (done),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_result_year       = r_out.year;
    assign o_result_month      = r_out.month;
    assign o_result_day        = r_out.day;
    assign o_year_out_of_range = r_out.out_of_range;

endmodule

// File: sv/cdad_check.sv
// port-level checker for the calendar date adder, bound to the top level
module cdad_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [13:0] o_result_year,
    input logic [3:0]  o_result_month,
    input logic [4:0]  o_result_day,
    input logic        o_year_out_of_range
);

    // result stays while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_year)
            && $stable(o_result_month) && $stable(o_result_day)
            && $stable(o_year_out_of_range))
        else $error("stalled result changed");

    // a normalized date is always in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result_month >= 4'd1 && o_result_month <= 4'd12
            && o_result_day >= 5'd1 && o_result_year <= 14'd9999)
        else $error("result date out of range");

    // saturated dates are the range ends
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_year_out_of_range |->
            (o_result_year == 14'd9999 && o_result_month == 4'd12 && o_result_day == 5'd31)
            || (o_result_year == 14'd0 && o_result_month == 4'd1 && o_result_day == 5'd1))
        else $error("saturated date wrong");

    // an accepted item keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after accepting an item");

    // no result without a prior item in flight
    a_nospur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without an item");

endmodule

bind calendar_date_add_days cdad_check u_cdad_check (.*);

// File: tb/sv/date_ledger_pkg.sv
// date shifter and result ledger for the calendar date adder bench
package date_ledger_pkg;

    import cdad_pkg::*;

    localparam int TOP_YEAR  = int'(YEAR_MAX);
    localparam int FIRST_MON = int'(MONTH_JAN);
    localparam int LAST_MON  = int'(MONTH_DEC);

    class date_ledger;

        t_result dates_due[$];
        int      n_logged;
        int      n_matched;
        int      n_over;
        int      n_under;
        int      fails;

        function int month_days(int yr, int mo);
            bit leap;
            leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
            case (mo)
                int'(MONTH_FEB): return leap ? 29 : 28;
                4, 6, 9, 11:     return 30;
                default:         return 31;
            endcase
        endfunction

        function t_result shift_date(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                                     logic signed [OFFSET_BITS-1:0] off);
            int      yr;
            int      mo;
            int      dy;
            t_result r;
            yr = y;
            mo = m;
            dy = d;
            if (mo < FIRST_MON) begin
                mo = FIRST_MON;
            end
            if (mo > LAST_MON) begin
                mo = LAST_MON;
            end
            dy = dy + off;
            while (dy > month_days(yr, mo) && yr <= TOP_YEAR) begin
                dy = dy - month_days(yr, mo);
                mo++;
                if (mo > LAST_MON) begin
                    mo = FIRST_MON;
                    yr++;
                end
            end
            while (dy < 1 && yr >= 0) begin
                mo--;
                if (mo < FIRST_MON) begin
                    mo = LAST_MON;
                    yr--;
                end
                dy = dy + month_days(yr, mo);
            end
            r.out_of_range = 1'b0;
            if (yr > TOP_YEAR) begin
                yr = TOP_YEAR;
                mo = LAST_MON;
                dy = int'(DAY_LAST);
                r.out_of_range = 1'b1;
            end else if (yr < 0) begin
                yr = 0;
                mo = FIRST_MON;
                dy = int'(DAY_FIRST);
                r.out_of_range = 1'b1;
            end
            r.year  = yr[13:0];
            r.month = mo[3:0];
            r.day   = dy[4:0];
            return r;
        endfunction

        function void log_request(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                                  logic signed [OFFSET_BITS-1:0] off);
            t_result r;
            r = shift_date(y, m, d, off);
            if (r.out_of_range && r.year == YEAR_MAX) begin
                n_over++;
            end else if (r.out_of_range) begin
                n_under++;
            end
            dates_due.push_back(r);
            n_logged++;
        endfunction

        function int pending();
            return dates_due.size();
        endfunction

        task report(string what, int got, int want);
            $display("mismatch on result %0d, %s: got %0d, want %0d",
                     n_matched, what, got, want);
            fails++;
        endtask

        task match_result(logic [13:0] y, logic [3:0] m, logic [4:0] d, logic flag);
            t_result want;
            if (dates_due.size() == 0) begin
                report("result with no item waiting", y, -1);
            end else begin
                want = dates_due.pop_front();
                if (y !== want.year) begin
                    report("year", y, want.year);
                end
                if (m !== want.month) begin
                    report("month", m, want.month);
                end
                if (d !== want.day) begin
                    report("day", d, want.day);
                end
                if (flag !== want.out_of_range) begin
                    report("out of range", flag, want.out_of_range);
                end
            end
            n_matched++;
        endtask

    endclass

endpackage

// File: tb/sv/tb_calendar_date_add_days.sv
// bench for the calendar date adder: directed and random dates under random stalls
module tb_calendar_date_add_days;

    timeunit 1ns;
    timeprecision 1ps;

    import cdad_pkg::*;
    import date_ledger_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 2200;
    localparam int BIG_STEP    = 2000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [13:0]                   i_start_year = '0;
    logic [3:0]                    i_start_month = MONTH_JAN;
    logic [4:0]                    i_start_day = DAY_FIRST;
    logic signed [OFFSET_BITS-1:0] i_day_offset = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [13:0]                   o_result_year;
    logic [3:0]                    o_result_month;
    logic [4:0]                    o_result_day;
    logic                          o_year_out_of_range;

    date_ledger ledger;
    int         send_idle_pct = 38;
    int         recv_idle_pct = 83;
    logic       hold_go = 1'b0;
    logic       hold_done = 1'b0;
    int         hold_left = 0;
    int         cycle_count = 0;
    int         n_long = 0;

    calendar_date_add_days i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_start_year        (i_start_year),
        .i_start_month       (i_start_month),
        .i_start_day         (i_start_day),
        .i_day_offset        (i_day_offset),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_result_year       (o_result_year),
        .o_result_month      (o_result_month),
        .o_result_day        (o_result_day),
        .o_year_out_of_range (o_year_out_of_range)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[calendar_date_add_days] ERROR");
            $finish;
        end
    end

    // receiver: one long hold-off on request, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            ledger.match_result(o_result_year, o_result_month, o_result_day,
                                o_year_out_of_range);
        end
    end

    task automatic send_date(input logic [13:0] y, input logic [3:0] m,
                             input logic [4:0] d, input int off);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_start_year  <= y;
        i_start_month <= m;
        i_start_day   <= d;
        i_day_offset  <= off[OFFSET_BITS-1:0];
        do begin
            @(posedge i_clk);
        end while (o_stall !== 1'b0);
        ledger.log_request(y, m, d, off[OFFSET_BITS-1:0]);
        if (off > BIG_STEP || off < -BIG_STEP) begin
            n_long++;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (ledger.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        int kind;
        int y;
        int m;
        int d;
        int off;
        kind = $urandom_range(99);
        y    = $urandom_range(9999);
        m    = $urandom_range(12, 1);
        d    = $urandom_range(31, 1);
        off  = int'($urandom_range(3000)) - 1500;
        if (kind < 10) begin
            off = int'($urandom_range(131071)) - 65536;
        end else if (kind < 20) begin
            // dates close to either end of the year range
            if ($urandom_range(1)) begin
                y   = 9999 - $urandom_range(5);
                off = $urandom_range(4000);
            end else begin
                y   = $urandom_range(5);
                off = -int'($urandom_range(4000));
            end
        end else if (kind < 30) begin
            y = $urandom_range(16383);
            m = $urandom_range(15);
            d = $urandom_range(31);
        end else if (kind < 40) begin
            // february around century years
            y   = 100 * $urandom_range(99);
            m   = MONTH_FEB;
            d   = $urandom_range(29, 27);
            off = int'($urandom_range(800)) - 400;
        end
        send_date(y[13:0], m[3:0], d[4:0], off);
    endtask

    initial begin
        ledger = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_date(14'd2024, MONTH_FEB, 5'd28, 1);
        send_date(14'd2023, MONTH_FEB, 5'd28, 1);
        send_date(14'd1900, MONTH_FEB, 5'd28, 1);
        send_date(14'd2000, MONTH_FEB, 5'd28, 1);
        send_date(14'd0, MONTH_FEB, 5'd28, 1);
        send_date(14'd0, MONTH_JAN, DAY_FIRST, 0);
        send_date(14'd0, MONTH_JAN, DAY_FIRST, -1);
        send_date(YEAR_MAX, MONTH_DEC, DAY_LAST, 0);
        send_date(YEAR_MAX, MONTH_DEC, DAY_LAST, 1);
        send_date(14'd2000, MONTH_JAN, DAY_FIRST, 65535);
        send_date(14'd2000, MONTH_JAN, DAY_FIRST, -65536);
        send_date(14'd0, MONTH_DEC, DAY_LAST, -65536);
        send_date(YEAR_MAX, MONTH_JAN, DAY_FIRST, 65535);
        send_date(14'd2021, 4'd0, 5'd15, 0);
        send_date(14'd2021, 4'd13, 5'd10, 0);
        send_date(14'd2021, 4'd15, 5'd31, 1);
        send_date(14'd2021, 4'd3, 5'd0, 0);
        send_date(14'd2021, 4'd4, DAY_LAST, 0);
        send_date(14'd2021, MONTH_DEC, DAY_LAST, 1);
        send_date(14'd2021, MONTH_JAN, DAY_FIRST, -1);
        send_date(14'd16383, MONTH_JAN, DAY_FIRST, 0);
        send_date(14'd10000, MONTH_JAN, 5'd5, -10);
        send_date(14'd10180, MONTH_JAN, DAY_FIRST, -65536);
        send_date(14'd12345, 4'd7, 5'd20, -200);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                drain();
                send_idle_pct = 83;
                recv_idle_pct <= 38;
            end else if (phase == 2) begin
                drain();
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                hold_go       <= 1'b1;
            end
            repeat (phase == 0 ? 80 : 85) begin
                send_random();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d dates in, %0d results checked, %0d with offsets past %0d days",
                 ledger.n_logged, ledger.n_matched, n_long, BIG_STEP);
        $display("saturated results: %0d past year 9999, %0d before year 0",
                 ledger.n_over, ledger.n_under);
        if (ledger.fails == 0) begin
            $display("[calendar_date_add_days] OK");
        end else begin
            $display("[calendar_date_add_days] ERROR");
        end
        $finish;
    end

endmodule
